[rtl/dcs_pkg.sv]
// ----------------------------------------------------------------------------
// dcs_pkg
// Types, codes and constants shared by the dock charger supervisor files.
// ----------------------------------------------------------------------------
package dcs_pkg;

  // field widths
  localparam int ADC_W      = 16;
  localparam int LEVEL_W    = 19;
  localparam int TRAVEL_W   = 32;
  localparam int QUAL_W     = 6;
  localparam int MOVE_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 19;
  localparam int PROD_W     = 28;

  // default checker timing
  localparam int CHECK_LIMIT_DEF  = 60;
  localparam int SETTLE_TICKS_DEF = 3;

  // item kinds
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  // adc conversion, level in units of 0.1 mV
  localparam logic [ADC_W-1:0]   ADC_OFFSET  = 16'd512;
  localparam logic [PROD_W-1:0]  LEVEL_SCALE = 28'd2398;
  localparam logic [PROD_W-1:0]  LEVEL_MIN   = 28'd15000;
  localparam logic [PROD_W-1:0]  LEVEL_MAX   = 28'd500000;

  localparam logic [QUAL_W-1:0]  GOOD_MAX    = 6'd63;

  // register reset values
  localparam logic [LEVEL_W-1:0] LOW_LEVEL_RST     = 19'd245000;
  localparam logic [LEVEL_W-1:0] FULL_LEVEL_RST    = 19'd275000;
  localparam logic [QUAL_W-1:0]  QUALIFY_TICKS_RST = 6'd30;
  localparam logic [MOVE_W-1:0]  MOVE_LIMIT_RST    = 16'd30;

  typedef enum logic [1:0] {
    CMD_NONE      = 2'd0,
    CMD_RELAY_ON  = 2'd1,
    CMD_RELAY_OFF = 2'd2
  } relay_cmd_t;

  typedef enum logic [1:0] {
    ST_OFF      = 2'd0,
    ST_TOUCHED  = 2'd1,
    ST_CHARGING = 2'd2
  } charge_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_LEVEL     = 2'd0,
    REG_FULL_LEVEL    = 2'd1,
    REG_QUALIFY_TICKS = 2'd2,
    REG_MOVE_LIMIT    = 2'd3
  } cfg_reg_t;

  // one item after the front stage
  typedef struct packed {
    logic                       func;
    logic                       relay_closed;
    logic [LEVEL_W-1:0]         level;
    logic [LEVEL_W-1:0]         battery;
    logic signed [TRAVEL_W-1:0] travel;
  } item_t;

endpackage

[rtl/dcs_in_if.sv]
// ----------------------------------------------------------------------------
// dcs_in_if
// Sample and tick channel of the dock charger supervisor.
// ----------------------------------------------------------------------------
interface dcs_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 func;
  logic [dcs_pkg::ADC_W-1:0]            adc_word;
  logic [dcs_pkg::LEVEL_W-1:0]          battery_level;
  logic                                 relay_closed;
  logic signed [dcs_pkg::TRAVEL_W-1:0]  left_travel_mm;
  logic signed [dcs_pkg::TRAVEL_W-1:0]  right_travel_mm;

  modport source (
    output valid, func, adc_word, battery_level, relay_closed,
           left_travel_mm, right_travel_mm,
    input  ready
  );
  modport sink (
    input  valid, func, adc_word, battery_level, relay_closed,
           left_travel_mm, right_travel_mm,
    output ready
  );
endinterface

[rtl/dcs_out_if.sv]
// ----------------------------------------------------------------------------
// dcs_out_if
// Result channel of the dock charger supervisor.
// ----------------------------------------------------------------------------
interface dcs_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  relay_command;
  logic [1:0]                  charge_status;
  logic [dcs_pkg::LEVEL_W-1:0] contact_level;

  modport source (
    output valid, relay_command, charge_status, contact_level,
    input  ready
  );
  modport sink (
    input  valid, relay_command, charge_status, contact_level,
    output ready
  );
endinterface

[rtl/dcs_cfg_if.sv]
// ----------------------------------------------------------------------------
// dcs_cfg_if
// Register write channel of the dock charger supervisor.
// ----------------------------------------------------------------------------
interface dcs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dcs_pkg::CFG_IDX_W-1:0]  index;
  logic [dcs_pkg::CFG_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

[rtl/dcs_front.sv]
// ----------------------------------------------------------------------------
// dcs_front
// Input register: converts the contact adc word to a level and averages
// the wheel travel as the item is taken in.
// ----------------------------------------------------------------------------
module dcs_front (
  input  logic            clk,
  input  logic            rst_n,
  dcs_in_if.sink          in_s,
  input  logic            take,
  output logic            item_valid,
  output dcs_pkg::item_t  item
);

  logic                                valid_r;
  logic                                valid_nxt;
  dcs_pkg::item_t                      item_r;
  logic                                load;
  logic [dcs_pkg::ADC_W-1:0]           adc_off;
  logic [dcs_pkg::PROD_W-1:0]          prod;
  logic [dcs_pkg::LEVEL_W-1:0]         level;
  logic signed [dcs_pkg::TRAVEL_W:0]   sum;
  logic signed [dcs_pkg::TRAVEL_W:0]   sum_adj;

  assign in_s.ready = !valid_r || take;
  assign load       = in_s.valid && in_s.ready;

  always_comb begin
    adc_off = in_s.adc_word - dcs_pkg::ADC_OFFSET;
    prod    = dcs_pkg::PROD_W'(adc_off) * dcs_pkg::LEVEL_SCALE;
    // below offset wraps negative, out of range reads as no voltage
    if (in_s.adc_word >= dcs_pkg::ADC_OFFSET && prod >= dcs_pkg::LEVEL_MIN &&
        prod <= dcs_pkg::LEVEL_MAX) begin
      level = prod[dcs_pkg::LEVEL_W-1:0];
    end else begin
      level = '0;
    end
    // average rounds toward zero
    sum     = {in_s.left_travel_mm[dcs_pkg::TRAVEL_W-1], in_s.left_travel_mm} +
              {in_s.right_travel_mm[dcs_pkg::TRAVEL_W-1], in_s.right_travel_mm};
    sum_adj = sum + (dcs_pkg::TRAVEL_W+1)'(sum[dcs_pkg::TRAVEL_W]);
  end

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.func         <= in_s.func;
      item_r.relay_closed <= in_s.relay_closed;
      item_r.level        <= level;
      item_r.battery      <= in_s.battery_level;
      item_r.travel       <= sum_adj[dcs_pkg::TRAVEL_W:1];
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

[rtl/dock_charger_supervisor_top.sv]
// ----------------------------------------------------------------------------
// dock_charger_supervisor_top
// Charging contact supervisor. Each transfer on the input channel is either
// a measurement sample or a one-second tick and gives exactly one result.
// A sample sets the contact level, the charge status and may command the
// relay off; ticks drive the relay-on qualification (settling ticks, then
// consecutive good checks). One item is taken every clock cycle unless the
// result channel stalls; a result passes from its item through the input
// register and then the decision stage that updates the supervisor state and
// loads the result register. Register writes are taken at any time and should
// be made while no item is in flight.
// ----------------------------------------------------------------------------
module dock_charger_supervisor_top #(
  parameter int CHECK_LIMIT  = dcs_pkg::CHECK_LIMIT_DEF,
  parameter int SETTLE_TICKS = dcs_pkg::SETTLE_TICKS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  dcs_in_if.sink    in_s,
  dcs_out_if.source out_s,
  dcs_cfg_if.sink   cfg_s
);

  localparam int RoundW  = $clog2(CHECK_LIMIT + 1);
  localparam int SettleW = $clog2(SETTLE_TICKS + 1);

  // registers
  logic [dcs_pkg::LEVEL_W-1:0]         low_level_r;
  logic [dcs_pkg::LEVEL_W-1:0]         full_level_r;
  logic [dcs_pkg::QUAL_W-1:0]          qualify_r;
  logic [dcs_pkg::MOVE_W-1:0]          move_limit_r;

  // supervisor state
  logic [dcs_pkg::LEVEL_W-1:0]         level_r,  level_nxt;
  logic                                mode_r,   mode_nxt;
  dcs_pkg::charge_status_t             status_r, status_nxt;
  logic                                busy_r,   busy_nxt;
  logic [SettleW-1:0]                  settle_r, settle_nxt;
  logic [RoundW-1:0]                   round_r,  round_nxt;
  logic [dcs_pkg::QUAL_W-1:0]          good_r,   good_nxt;
  logic signed [dcs_pkg::TRAVEL_W-1:0] start_r,  start_nxt;

  // result register
  logic                                out_valid_r, out_valid_nxt;
  dcs_pkg::relay_cmd_t                 out_cmd_r;
  dcs_pkg::charge_status_t             out_status_r;
  logic [dcs_pkg::LEVEL_W-1:0]         out_level_r;

  logic                                item_valid;
  dcs_pkg::item_t                      item;
  logic                                advance;
  dcs_pkg::relay_cmd_t                 cmd;
  logic signed [dcs_pkg::TRAVEL_W:0]   diff;
  logic [dcs_pkg::TRAVEL_W:0]          travel_gap;
  logic                                moved;
  logic [RoundW-1:0]                   round_inc;
  logic [dcs_pkg::QUAL_W-1:0]          good_inc;

  dcs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_s       (in_s),
    .take       (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  assign advance = item_valid && (!out_valid_r || out_s.ready);

  // register writes
  assign cfg_s.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_level_r  <= dcs_pkg::LOW_LEVEL_RST;
      full_level_r <= dcs_pkg::FULL_LEVEL_RST;
      qualify_r    <= dcs_pkg::QUALIFY_TICKS_RST;
      move_limit_r <= dcs_pkg::MOVE_LIMIT_RST;
    end else if (cfg_s.valid) begin
      case (dcs_pkg::cfg_reg_t'(cfg_s.index))
        dcs_pkg::REG_LOW_LEVEL:     low_level_r  <= cfg_s.data;
        dcs_pkg::REG_FULL_LEVEL:    full_level_r <= cfg_s.data;
        dcs_pkg::REG_QUALIFY_TICKS: qualify_r    <= cfg_s.data[dcs_pkg::QUAL_W-1:0];
        dcs_pkg::REG_MOVE_LIMIT:    move_limit_r <= cfg_s.data[dcs_pkg::MOVE_W-1:0];
        default: ;
      endcase
    end
  end

  // travel since the relay was closed
  always_comb begin
    diff       = {item.travel[dcs_pkg::TRAVEL_W-1], item.travel} -
                 {start_r[dcs_pkg::TRAVEL_W-1], start_r};
    travel_gap = diff[dcs_pkg::TRAVEL_W] ? (dcs_pkg::TRAVEL_W+1)'(0) - diff : diff;
    moved      = travel_gap >= (dcs_pkg::TRAVEL_W+1)'(move_limit_r);
  end

  always_comb begin
    cmd        = dcs_pkg::CMD_NONE;
    level_nxt  = level_r;
    mode_nxt   = mode_r;
    status_nxt = status_r;
    busy_nxt   = busy_r;
    settle_nxt = settle_r;
    round_nxt  = round_r;
    good_nxt   = good_r;
    start_nxt  = start_r;
    round_inc  = round_r + RoundW'(1);
    good_inc   = (good_r < dcs_pkg::GOOD_MAX) ? good_r + dcs_pkg::QUAL_W'(1) : good_r;

    if (item.func == dcs_pkg::FUNC_SAMPLE) begin
      level_nxt = item.level;
      if (full_level_r < item.battery) begin
        cmd        = dcs_pkg::CMD_RELAY_OFF;
        mode_nxt   = 1'b0;
        status_nxt = dcs_pkg::ST_OFF;
      end else if (item.relay_closed) begin
        status_nxt = dcs_pkg::ST_CHARGING;
        if (item.level < low_level_r || moved) begin
          cmd        = dcs_pkg::CMD_RELAY_OFF;
          mode_nxt   = 1'b0;
          status_nxt = dcs_pkg::ST_OFF;
        end
      end else if (item.level > low_level_r) begin
        status_nxt = dcs_pkg::ST_TOUCHED;
        // checker marked busy at once so a second touch cannot restart it
        if (!busy_r) begin
          mode_nxt   = 1'b1;
          busy_nxt   = 1'b1;
          settle_nxt = '0;
          round_nxt  = '0;
          good_nxt   = '0;
        end
      end else begin
        status_nxt = dcs_pkg::ST_OFF;
      end
    end else if (busy_r) begin
      if (settle_r < SettleW'(SETTLE_TICKS)) begin
        settle_nxt = settle_r + SettleW'(1);
      end else begin
        round_nxt = round_inc;
        if (round_inc >= RoundW'(CHECK_LIMIT) || !mode_r) begin
          busy_nxt   = 1'b0;
          settle_nxt = '0;
          round_nxt  = '0;
          good_nxt   = '0;
        end else begin
          good_nxt = (level_r >= low_level_r) ? good_inc : '0;
          if (good_nxt > qualify_r) begin
            cmd        = dcs_pkg::CMD_RELAY_ON;
            start_nxt  = item.travel;
            busy_nxt   = 1'b0;
            settle_nxt = '0;
            round_nxt  = '0;
            good_nxt   = '0;
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_s.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= '0;
      mode_r      <= 1'b0;
      status_r    <= dcs_pkg::ST_OFF;
      busy_r      <= 1'b0;
      settle_r    <= '0;
      round_r     <= '0;
      good_r      <= '0;
      start_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        level_r  <= level_nxt;
        mode_r   <= mode_nxt;
        status_r <= status_nxt;
        busy_r   <= busy_nxt;
        settle_r <= settle_nxt;
        round_r  <= round_nxt;
        good_r   <= good_nxt;
        start_r  <= start_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_cmd_r    <= cmd;
      out_status_r <= status_nxt;
      out_level_r  <= level_nxt;
    end
  end

  assign out_s.valid         = out_valid_r;
  assign out_s.relay_command = out_cmd_r;
  assign out_s.charge_status = out_status_r;
  assign out_s.contact_level = out_level_r;

`ifndef SYNTH
  // counters only run while the checker is busy
  a_idle_counters_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (settle_r == '0) && (round_r == '0) && (good_r == '0))
    else $error("checker counters left over while idle");

  // a tick with the checker idle issues no command
  a_idle_tick_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (item.func == dcs_pkg::FUNC_TICK) && !busy_r
    |=> out_cmd_r == dcs_pkg::CMD_NONE)
    else $error("command issued on an idle tick");

  // relay on always ends the qualification
  a_on_stops_checker: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (cmd == dcs_pkg::CMD_RELAY_ON) |=> !busy_r)
    else $error("checker still busy after relay on");

  // relay on only comes from a tick
  a_on_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (cmd == dcs_pkg::CMD_RELAY_ON) |-> item.func == dcs_pkg::FUNC_TICK)
    else $error("relay on from a sample");

  // the result register holds while the next stage stalls
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_s.ready |-> !advance ##1 out_valid_r)
    else $error("result register overwritten under stall");
`endif

endmodule
